/* rtl/drme_pkg.sv */
// ----------------------------------------------------------------------------
// drme_pkg
// Shared types and constants for the data rate exponent/mantissa encoder.
// ----------------------------------------------------------------------------
package drme_pkg;

  localparam int BAUD_W  = 20;
  localparam int XTAL_W  = 26;
  localparam int QUO_W   = 25;
  localparam int SHF_W   = 10;
  localparam int POS_W   = 5;
  localparam int EXP_W   = 4;
  localparam int MANT_W  = 8;

  // quotient bits of baud * 2^29 / crystal, one per cell
  localparam int DIV_STEPS = BAUD_W + 29;

  localparam logic [BAUD_W-1:0] RATE_MIN  = 20'd600;
  localparam logic [BAUD_W-1:0] RATE_MAX  = 20'd500000;
  localparam logic [XTAL_W-1:0] XTAL_RST  = 26'd26000000;
  localparam logic [EXP_W-1:0]  EXP_MAX   = 4'd15;
  localparam logic [POS_W-1:0]  POS_BIAS  = 5'd9;

  typedef struct packed {
    logic              vld;
    logic              bad;
    logic              big;
    logic [XTAL_W-1:0] rem;
    logic [BAUD_W-1:0] num;
    logic [QUO_W-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic             vld;
    logic             bad;
    logic [EXP_W-1:0] expo;
    logic [SHF_W-1:0] shf;
  } norm_t;

endpackage

/* rtl/drme_div_cell.sv */
// ----------------------------------------------------------------------------
// drme_div_cell
// One restoring-division cell: produces one quotient bit per item.
// ----------------------------------------------------------------------------
module drme_div_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [drme_pkg::XTAL_W-1:0] xtal,
  input  drme_pkg::div_t              din,
  output drme_pkg::div_t              dout
);
  import drme_pkg::*;

  div_t              stage_r;
  div_t              stage_nxt;
  logic [XTAL_W:0]   trial;
  logic [XTAL_W:0]   diff;
  logic              take;

  always_comb begin
    trial = {din.rem, din.num[BAUD_W-1]};
    diff  = trial - {1'b0, xtal};
    take  = (trial >= {1'b0, xtal});
    stage_nxt      = din;
    stage_nxt.rem  = take ? diff[XTAL_W-1:0] : trial[XTAL_W-1:0];
    stage_nxt.num  = {din.num[BAUD_W-2:0], 1'b0};
    stage_nxt.quo  = {din.quo[QUO_W-2:0], take};
    // any one pushed past the kept quotient bits means the exponent overflows
    stage_nxt.big  = din.big | din.quo[QUO_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign dout = stage_r;

endmodule

/* rtl/drme_norm.sv */
// ----------------------------------------------------------------------------
// drme_norm
// Leading-one search on the quotient, exponent and mantissa alignment.
// ----------------------------------------------------------------------------
module drme_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  drme_pkg::div_t  din,
  output drme_pkg::norm_t dout
);
  import drme_pkg::*;

  norm_t            norm_r;
  norm_t            norm_nxt;
  logic [POS_W-1:0] pos;
  logic [EXP_W-1:0] expo;
  logic [QUO_W-1:0] shifted;

  always_comb begin
    pos = '0;
    for (int i = 0; i < QUO_W; i++) begin
      if (din.quo[i]) begin
        pos = POS_W'(i);
      end
    end
    expo     = (pos > POS_BIAS) ? EXP_W'(pos - POS_BIAS) : '0;
    shifted  = din.quo >> expo;
    norm_nxt.vld  = din.vld;
    norm_nxt.bad  = din.bad | din.big;
    norm_nxt.expo = expo;
    norm_nxt.shf  = shifted[SHF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r.vld <= 1'b0;
    end else if (en) begin
      norm_r <= norm_nxt;
    end
  end

  assign dout = norm_r;

endmodule

/* rtl/data_rate_exponent_mantissa_encoder_unit.sv */
// ----------------------------------------------------------------------------
// data_rate_exponent_mantissa_encoder_unit
// Converts a baud rate into a 4-bit exponent and 8-bit mantissa.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries in_baud_rate; one transfer per
//   cycle is taken while in_ready is high. Each transfer yields exactly one
//   result on the out_valid/out_ready channel: out_ok, out_rate_exponent,
//   out_rate_mantissa (exponent and mantissa are zero when out_ok is low).
//   cfg_we/cfg_wdata write the crystal frequency; write only while idle.
//   Each result passes the row of 49 division cells (one quotient bit each),
//   the normalize stage and the output register. Throughput: one item per
//   cycle while in_ready is high.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   crystal register with 26000000.
//   When the receiver stalls with a result held, the pipeline keeps
//   advancing until a valid item reaches the normalize stage, then holds;
//   in_ready drops only then.
// ----------------------------------------------------------------------------
module data_rate_exponent_mantissa_encoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [drme_pkg::BAUD_W-1:0]   in_baud_rate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [drme_pkg::EXP_W-1:0]    out_rate_exponent,
  output logic [drme_pkg::MANT_W-1:0]   out_rate_mantissa,
  input  logic                          cfg_we,
  input  logic [drme_pkg::XTAL_W-1:0]   cfg_wdata
);
  import drme_pkg::*;

  logic [XTAL_W-1:0] xtal_r;
  div_t              chain [0:DIV_STEPS];
  norm_t             norm;
  logic              adv;
  logic              ld_out;

  logic              out_valid_r;
  logic              out_ok_r;
  logic [EXP_W-1:0]  out_exp_r;
  logic [MANT_W-1:0] out_mant_r;

  logic              ok_nxt;
  logic [EXP_W-1:0]  exp_nxt;
  logic [MANT_W-1:0] mant_nxt;
  logic [SHF_W:0]    rnd;
  logic [SHF_W-1:0]  mfull;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xtal_r <= XTAL_RST;
    end else if (cfg_we) begin
      xtal_r <= cfg_wdata;
    end
  end

  assign adv      = !norm.vld || !out_valid_r || out_ready;
  assign ld_out   = norm.vld && (!out_valid_r || out_ready);
  assign in_ready = adv;

  always_comb begin
    chain[0].vld = in_valid;
    chain[0].bad = (in_baud_rate < RATE_MIN) || (in_baud_rate > RATE_MAX) ||
                   (xtal_r == '0);
    chain[0].big = 1'b0;
    chain[0].rem = '0;
    chain[0].num = in_baud_rate;
    chain[0].quo = '0;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    drme_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .xtal  (xtal_r),
      .din   (chain[g]),
      .dout  (chain[g+1])
    );
  end

  drme_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .din   (chain[DIV_STEPS]),
    .dout  (norm)
  );

  // round half up, then fold a mantissa carry into the exponent
  always_comb begin
    rnd      = {1'b0, norm.shf} + (SHF_W+1)'(1);
    mfull    = rnd[SHF_W:1];
    ok_nxt   = !norm.bad;
    exp_nxt  = norm.expo;
    mant_nxt = '0;
    if (mfull[MANT_W+1]) begin
      ok_nxt  = !norm.bad && (norm.expo != EXP_MAX);
      exp_nxt = norm.expo + EXP_W'(1);
    end else if (mfull[MANT_W]) begin
      mant_nxt = mfull[MANT_W-1:0];
    end
    if (!ok_nxt) begin
      exp_nxt  = '0;
      mant_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_ok_r   <= ok_nxt;
      out_exp_r  <= exp_nxt;
      out_mant_r <= mant_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_rate_exponent = out_exp_r;
  assign out_rate_mantissa = out_mant_r;

endmodule
